// ===== hdl/assert_macros.svh =====
// assertion macros shared by the word wrap rtl
// each check is sampled on the rising clock edge and is off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge
`define CHK_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold at any edge where the antecedent holds
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/wwr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the greedy word wrap stream
// no dependencies
package wwr_pkg;

  // widest line the word buffer can hold
  localparam int MAX_WIDTH = 62;

  // line and word lengths saturate at LEN_CAP
  localparam int              LEN_W   = 7;
  localparam logic [LEN_W-1:0] LEN_CAP = 7'd127;
  localparam logic [LEN_W-1:0] MAX_W   = LEN_W'(MAX_WIDTH);

  // word count, buffer index and two-bank buffer address
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  // characters
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_CR  = 8'd13;

  // one output run: newlines, a space, a buffered word, then a single tail word
  typedef struct packed {
    logic [1:0]       nl_count;
    logic             space;
    logic [CNT_W-1:0] word_len;
    logic             bank;
    logic             tail;
    logic [7:0]       tail_byte;
    logic             done;
    logic             overlong;
  } cmd_t;

  // back end hands a buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // write port of the word buffer
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage

// ===== hdl/greedy_word_wrap_stream.sv =====
`timescale 1ns / 1ps
// greedy word wrap stream, top level
// depends on wwr_pkg, wwr_ram, wwr_cmdq, wwr_front and wwr_back
//
// Input channel: push/full with byte_value and end_of_text; a word is taken at an
//   edge with push high and full low. end_of_text flushes the last word, emits the
//   closing newline (text_done) and readies the block for a new text.
// Output channel: empty/pop; one text byte per word, last_of_run marks the final
//   byte caused by an input word, overlong_flag is the sticky overflow status.
// Configuration: line_width is written by cfg_write/cfg_data; the user must write
//   it only while idle, the block itself does not enforce it. The run of an
//   input word goes through the command queue, run registers and output register.
// Throughput: the front end takes one word per cycle while full is low; the
//   sequencer emits one byte per cycle while the receiver pops, drawing on its
//   queue and the two-bank word buffer. full rises when the command queue is full
//   or the bank for the next word still drains.
// A stalled receiver holds the output register, then the queue fills and full
//   rises. Reset (synchronous) clears all control state and sets line_width to
//   62; the word buffer needs no clearing.
module greedy_word_wrap_stream #(
  parameter int CMDQ_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [5:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_value,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       text_done,
  output logic       overlong_flag
);
  import wwr_pkg::*;

  logic [5:0]        line_width;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  cmd_t              q_wdata;
  cmd_t              q_rdata;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  release_t          rel;

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 6'd62;
    end else if (cfg_write) begin
      line_width <= cfg_data;
    end
  end

  // front end
  wwr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .line_width  (line_width),
    .push        (push),
    .full        (full),
    .byte_value  (byte_value),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_wdata),
    .ram_wr      (ram_wr),
    .rel         (rel)
  );

  // command queue
  wwr_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // two-bank word buffer
  wwr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_word_store (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // output sequencer
  wwr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cmd         (q_rdata),
    .q_pop         (q_pop),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .rel           (rel),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .text_done     (text_done),
    .overlong_flag (overlong_flag)
  );

endmodule

// ===== hdl/wwr_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module wwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/wwr_cmdq.sv =====
`timescale 1ns / 1ps
// short command queue between the wrap front end and the output sequencer
// depends on wwr_pkg
module wwr_cmdq #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wwr_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output wwr_pkg::cmd_t rdata,
  output logic          empty
);
  import wwr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/wwr_front.sv =====
`timescale 1ns / 1ps
// wrap front end: takes text bytes, collects words and issues output runs
// depends on wwr_pkg and assert_macros.svh
`include "assert_macros.svh"
module wwr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [5:0]        line_width,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        byte_value,
  input  logic              end_of_text,
  input  logic              q_full,
  output logic              q_push,
  output wwr_pkg::cmd_t     q_cmd,
  output wwr_pkg::ram_wr_t  ram_wr,
  input  wwr_pkg::release_t rel
);
  import wwr_pkg::*;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v < LEN_CAP) ? v + 1'b1 : LEN_CAP;
  endfunction

  // wrap state
  logic [LEN_W-1:0] word_length, word_length_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic             inside_word, inside_word_next;
  logic             word_committed, word_committed_next;
  logic             prev_was_newline, prev_was_newline_next;
  logic             paragraph_pending, paragraph_pending_next;
  logic             overlong_seen, overlong_seen_next;
  logic             cur_bank;
  logic [1:0]       bank_busy;

  logic             accept;
  logic             blank;
  logic [LEN_W-1:0] w_eff;
  logic             cmd_valid;
  logic             wr_en;
  logic             para_start;
  logic [LEN_W-1:0] ll_p;
  logic [LEN_W-1:0] wl_p;
  logic             committed_p;

  // placement of a finished word
  logic [LEN_W:0]   pw_sum;
  logic             pw_nl;
  logic [LEN_W-1:0] ll_a;
  logic             pw_sp;
  logic [LEN_W-1:0] ll_b;
  logic [LEN_W:0]   ll_sum;
  logic [LEN_W-1:0] pw_ll;

  // stall while the queue is full or the bank for the next word still drains
  assign full   = q_full || bank_busy[cur_bank];
  assign accept = push && !full;
  assign blank  = byte_value inside {CH_SP, [CH_TAB:CH_CR]};
  assign w_eff  = ({1'b0, line_width} > MAX_W) ? MAX_W : {1'b0, line_width};

  assign pw_sum = {1'b0, line_length} + {{LEN_W{1'b0}}, 1'b1} + {1'b0, word_length};
  assign pw_nl  = (line_length != '0) && (pw_sum > {1'b0, w_eff});
  assign ll_a   = pw_nl ? '0 : line_length;
  assign pw_sp  = (ll_a != '0);
  assign ll_b   = pw_sp ? sat_inc(ll_a) : ll_a;
  assign ll_sum = {1'b0, ll_b} + {1'b0, word_length};
  assign pw_ll  = (ll_sum > {1'b0, LEN_CAP}) ? LEN_CAP : ll_sum[LEN_W-1:0];

  // a word byte that opens a new word
  assign para_start  = !inside_word && paragraph_pending;
  assign ll_p        = para_start ? '0 : line_length;
  assign wl_p        = inside_word ? word_length : '0;
  assign committed_p = inside_word && word_committed;

  // classify the byte and build its output run
  always_comb begin
    word_length_next       = word_length;
    line_length_next       = line_length;
    inside_word_next       = inside_word;
    word_committed_next    = word_committed;
    prev_was_newline_next  = prev_was_newline;
    paragraph_pending_next = paragraph_pending;
    overlong_seen_next     = overlong_seen;
    cmd_valid              = 1'b0;
    wr_en                  = 1'b0;
    q_cmd                  = '0;
    q_cmd.bank             = cur_bank;
    if (end_of_text) begin
      if (inside_word && !word_committed) begin
        q_cmd.nl_count = {1'b0, pw_nl};
        q_cmd.space    = pw_sp;
        q_cmd.word_len = word_length[CNT_W-1:0];
      end
      q_cmd.tail             = 1'b1;
      q_cmd.tail_byte        = CH_NL;
      q_cmd.done             = 1'b1;
      cmd_valid              = 1'b1;
      word_length_next       = '0;
      line_length_next       = '0;
      inside_word_next       = 1'b0;
      word_committed_next    = 1'b0;
      prev_was_newline_next  = 1'b0;
      paragraph_pending_next = 1'b0;
    end else if (blank) begin
      if (inside_word) begin
        if (!word_committed) begin
          q_cmd.nl_count   = {1'b0, pw_nl};
          q_cmd.space      = pw_sp;
          q_cmd.word_len   = word_length[CNT_W-1:0];
          cmd_valid        = 1'b1;
          line_length_next = pw_ll;
        end
        inside_word_next    = 1'b0;
        word_committed_next = 1'b0;
        word_length_next    = '0;
      end else if (prev_was_newline && byte_value == CH_NL) begin
        paragraph_pending_next = 1'b1;
        line_length_next       = '0;
      end
      prev_was_newline_next = (byte_value == CH_NL);
    end else begin
      prev_was_newline_next = 1'b0;
      inside_word_next      = 1'b1;
      line_length_next      = ll_p;
      word_length_next      = wl_p;
      word_committed_next   = committed_p;
      if (para_start) begin
        q_cmd.nl_count         = 2'd2;
        cmd_valid              = 1'b1;
        paragraph_pending_next = 1'b0;
      end
      if (committed_p) begin
        // overlong word streams straight out
        q_cmd.tail       = 1'b1;
        q_cmd.tail_byte  = byte_value;
        cmd_valid        = 1'b1;
        word_length_next = sat_inc(wl_p);
        line_length_next = sat_inc(ll_p);
      end else if (wl_p < w_eff && wl_p < MAX_W) begin
        wr_en            = 1'b1;
        word_length_next = wl_p + 1'b1;
      end else begin
        // word just outgrew the line: own line, flush buffer, then this byte
        overlong_seen_next  = 1'b1;
        word_committed_next = 1'b1;
        if (ll_p != '0) begin
          q_cmd.nl_count = 2'd1;
        end
        q_cmd.word_len   = wl_p[CNT_W-1:0];
        q_cmd.tail       = 1'b1;
        q_cmd.tail_byte  = byte_value;
        cmd_valid        = 1'b1;
        word_length_next = sat_inc(wl_p);
        line_length_next = sat_inc(wl_p);
      end
    end
    q_cmd.overlong = overlong_seen_next;
  end

  assign q_push      = accept && cmd_valid;
  assign ram_wr.en   = accept && wr_en;
  assign ram_wr.addr = {cur_bank, wl_p[IDX_W-1:0]};
  assign ram_wr.data = byte_value;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length       <= '0;
      line_length       <= '0;
      inside_word       <= 1'b0;
      word_committed    <= 1'b0;
      prev_was_newline  <= 1'b0;
      paragraph_pending <= 1'b0;
      overlong_seen     <= 1'b0;
    end else if (accept) begin
      word_length       <= word_length_next;
      line_length       <= line_length_next;
      inside_word       <= inside_word_next;
      word_committed    <= word_committed_next;
      prev_was_newline  <= prev_was_newline_next;
      paragraph_pending <= paragraph_pending_next;
      overlong_seen     <= overlong_seen_next;
    end
  end

  // buffer banks: a queued word holds its bank until the back end has read it
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank  <= 1'b0;
      bank_busy <= 2'b00;
    end else begin
      if (rel.valid) begin
        bank_busy[rel.bank] <= 1'b0;
      end
      if (q_push && q_cmd.word_len != '0) begin
        bank_busy[cur_bank] <= 1'b1;
        cur_bank            <= !cur_bank;
      end
    end
  end

  `CHK_IMPLY(a_write_free_bank, clk, rst, ram_wr.en, !bank_busy[cur_bank], "word write into a bank still being read")
  `CHK_IMPLY(a_push_room, clk, rst, q_push, !q_full, "command pushed into a full queue")
  `CHK_IMPLY(a_release_busy, clk, rst, rel.valid, bank_busy[rel.bank], "release of a bank that is not held")

endmodule

// ===== hdl/wwr_back.sv =====
`timescale 1ns / 1ps
// output sequencer: expands queued runs into single bytes behind an output register
// depends on wwr_pkg and assert_macros.svh
`include "assert_macros.svh"
module wwr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  wwr_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic [wwr_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output wwr_pkg::release_t          rel,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic                       last_of_run,
  output logic                       text_done,
  output logic                       overlong_flag
);
  import wwr_pkg::*;

  // run being expanded
  logic             active;
  logic [1:0]       nl_left;
  logic             space_left;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] word_len;
  logic             bank;
  logic             tail_left;
  logic [7:0]       tail_byte;
  logic             done_flag;
  logic             ovl;
  logic             out_valid;

  logic             can_emit;
  logic             emit;
  logic             run_end;
  logic             fin;
  logic             load;
  logic [1:0]       nl_after;
  logic             sp_after;
  logic [CNT_W-1:0] idx_after;
  logic             tail_after;
  logic [7:0]       emit_byte;

  assign can_emit = !out_valid || pop;
  assign emit     = active && can_emit;

  // next word of the run, in order newlines, space, buffered word, tail
  always_comb begin
    nl_after   = nl_left;
    sp_after   = space_left;
    idx_after  = idx;
    tail_after = tail_left;
    emit_byte  = tail_byte;
    if (nl_left != 2'd0) begin
      emit_byte = CH_NL;
      nl_after  = nl_left - 2'd1;
    end else if (space_left) begin
      emit_byte = CH_SP;
      sp_after  = 1'b0;
    end else if (idx != word_len) begin
      emit_byte = rd_data;
      idx_after = idx + 1'b1;
    end else begin
      tail_after = 1'b0;
    end
  end

  assign run_end = (nl_after == 2'd0) && !sp_after && (idx_after == word_len) && !tail_after;
  assign fin     = emit && run_end;
  assign load    = !q_empty && (!active || fin);
  assign q_pop   = load;

  // buffer read address leads the run index, so the registered read data belongs to idx
  always_comb begin
    if (load) begin
      rd_addr = {q_cmd.bank, {IDX_W{1'b0}}};
    end else if (emit) begin
      rd_addr = {bank, idx_after[IDX_W-1:0]};
    end else begin
      rd_addr = {bank, idx[IDX_W-1:0]};
    end
  end

  assign rel.valid = fin && (word_len != '0);
  assign rel.bank  = bank;

  // run registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (fin) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nl_left    <= q_cmd.nl_count;
      space_left <= q_cmd.space;
      idx        <= '0;
      word_len   <= q_cmd.word_len;
      bank       <= q_cmd.bank;
      tail_left  <= q_cmd.tail;
      tail_byte  <= q_cmd.tail_byte;
      done_flag  <= q_cmd.done;
      ovl        <= q_cmd.overlong;
    end else if (emit) begin
      nl_left    <= nl_after;
      space_left <= sp_after;
      idx        <= idx_after;
      tail_left  <= tail_after;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= emit_byte;
      last_of_run   <= run_end;
      text_done     <= done_flag && run_end;
      overlong_flag <= ovl;
    end
  end

  assign empty = !out_valid;

  `CHK_IMPLY(a_run_not_exhausted, clk, rst, active, (nl_left != 2'd0) || space_left || (idx != word_len) || tail_left, "active run with nothing left")
  `CHK_IMPLY(a_done_is_last, clk, rst, out_valid && text_done, last_of_run, "closing newline not last of its run")
  `CHK_IMPLY(a_load_no_run, clk, rst, load && active, fin, "new run loaded over an unfinished one")

endmodule

// ===== bench/tb_greedy_word_wrap_stream.sv =====
`timescale 1ns / 1ps
// testbench for greedy_word_wrap_stream: directed table then random texts,
// each output word checked against a typed row or a line-filling predictor in this file
// depends on wwr_pkg and the greedy_word_wrap_stream rtl
module tb_greedy_word_wrap_stream;
  import wwr_pkg::*;

  localparam int RUN_LIMIT = 200_000;
  localparam int SETTLE    = 12;
  localparam int RND_ITEMS = 70;

  // one output word as the block should present it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
    logic       ovf;
  } wrap_out_t;

  // directed table rows: a text byte, an end of text or a width write
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_END,
    ROW_WIDTH
  } row_kind_e;

  // typed rows carry their expectation: no output word, or one that ends the run
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] val;
    logic       typed;
    logic       has_out;
    logic [7:0] ch;
    logic       done;
    logic       ovf;
  } row_t;

  localparam int NROWS = 30;
  localparam row_t DIRECTED [NROWS] = '{
    '{ROW_END,   8'h00, 1'b1, 1'b1, CH_NL, 1'b1, 1'b0},  // empty text
    '{ROW_BYTE,  8'h09, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0D, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h61, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0A, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0A, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // paragraph mark
    '{ROW_BYTE,  8'h62, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0B, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0C, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_END,   8'hA5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_WIDTH, 8'd1,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0A, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // paragraph at start
    '{ROW_BYTE,  8'h0A, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h79, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // word outgrows width
    '{ROW_BYTE,  8'h7A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h0A, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_END,   8'h00, 1'b1, 1'b1, CH_NL, 1'b1, 1'b1},  // pending paragraph dropped
    '{ROW_WIDTH, 8'd0,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h71, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h72, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_BYTE,  8'h73, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_END,   8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_WIDTH, 8'd63, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // above the buffer size
    '{ROW_END,   8'h00, 1'b1, 1'b1, CH_NL, 1'b1, 1'b1}
  };

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [5:0] cfg_data;
  logic       push;
  logic       full;
  logic [7:0] byte_value;
  logic       end_of_text;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       text_done;
  logic       overlong_flag;

  greedy_word_wrap_stream DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .byte_value   (byte_value),
    .end_of_text  (end_of_text),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .text_done    (text_done),
    .overlong_flag(overlong_flag)
  );

  // predictor state, mirrors the block after each accepted word
  logic [5:0] width_reg;
  logic [7:0] word_buf [MAX_WIDTH];
  int         word_len;
  int         line_len;
  bit         in_word;
  bit         streaming;
  bit         prev_nl;
  bit         para_pending;
  bit         overlong_seen;

  wrap_out_t  run_q[$];
  wrap_out_t  expected_bytes[$];

  int         tx_idle_pct;
  int         rx_idle_pct;
  int         errors;
  int         bytes_checked;
  int         words_fed;
  int         rnd_items;
  int         widths_used;
  int unsigned cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: pop at random according to the current stall rate
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  // compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    wrap_out_t want;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: nothing expected, got %0d", out_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %0d, got %0d", want.ch, out_byte);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          errors++;
        end
        if (text_done !== want.done) begin
          $error("text_done: expected %0d, got %0d", want.done, text_done);
          errors++;
        end
        if (overlong_flag !== want.ovf) begin
          $error("overlong_flag: expected %0d, got %0d", want.ovf, overlong_flag);
          errors++;
        end
      end
    end
  end

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SP || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic int sat_inc(int v);
    return (v < int'(LEN_CAP)) ? v + 1 : int'(LEN_CAP);
  endfunction

  function automatic void emit(logic [7:0] b, logic done);
    wrap_out_t o;
    o.ch   = b;
    o.last = 1'b0;
    o.done = done;
    o.ovf  = 1'b0;
    run_q.push_back(o);
  endfunction

  // put a fitting word on the line, breaking first if it would overrun
  function automatic void place_word(int w);
    int i;
    if (line_len > 0 && line_len + 1 + word_len > w) begin
      emit(CH_NL, 1'b0);
      line_len = 0;
    end
    if (line_len > 0) begin
      emit(CH_SP, 1'b0);
      line_len = sat_inc(line_len);
    end
    for (i = 0; i < word_len && i < MAX_WIDTH; i++)
      emit(word_buf[i], 1'b0);
    line_len = (line_len + word_len > int'(LEN_CAP)) ? int'(LEN_CAP) : line_len + word_len;
  endfunction

  // output words caused by one input word, left in run_q
  function automatic void wrap_predict(logic [7:0] b, logic eot);
    int w;
    int i;
    run_q.delete();
    w = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    if (eot) begin
      if (in_word && !streaming)
        place_word(w);
      emit(CH_NL, 1'b1);
      word_len     = 0;
      line_len     = 0;
      in_word      = 1'b0;
      streaming    = 1'b0;
      prev_nl      = 1'b0;
      para_pending = 1'b0;
    end else if (is_blank(b)) begin
      if (in_word) begin
        if (!streaming)
          place_word(w);
        in_word   = 1'b0;
        streaming = 1'b0;
        word_len  = 0;
      end else if (prev_nl && b == CH_NL) begin
        para_pending = 1'b1;
        line_len     = 0;
      end
      prev_nl = (b == CH_NL);
    end else begin
      prev_nl = 1'b0;
      if (!in_word) begin
        in_word   = 1'b1;
        streaming = 1'b0;
        word_len  = 0;
        if (para_pending) begin
          emit(CH_NL, 1'b0);
          emit(CH_NL, 1'b0);
          para_pending = 1'b0;
          line_len     = 0;
        end
      end
      if (streaming) begin
        // overlong word goes straight out
        emit(b, 1'b0);
        word_len = sat_inc(word_len);
        line_len = sat_inc(line_len);
      end else if (word_len < w && word_len < MAX_WIDTH) begin
        word_buf[word_len] = b;
        word_len++;
      end else begin
        // word just outgrew the width: own line, flush what was held
        overlong_seen = 1'b1;
        streaming     = 1'b1;
        if (line_len > 0)
          emit(CH_NL, 1'b0);
        for (i = 0; i < word_len && i < MAX_WIDTH; i++)
          emit(word_buf[i], 1'b0);
        emit(b, 1'b0);
        word_len = sat_inc(word_len);
        line_len = word_len;
      end
    end
    foreach (run_q[k]) begin
      run_q[k].last = (k == run_q.size() - 1);
      run_q[k].ovf  = overlong_seen;
    end
  endfunction

  // hand one word to the block, then predict what it causes
  task automatic feed(input logic [7:0] b, input logic eot, input bit use_model);
    // sender idles on a share of cycles given by the current stall rate
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    byte_value  <= b;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    words_fed++;
    wrap_predict(b, eot);
    if (use_model)
      foreach (run_q[i]) expected_bytes.push_back(run_q[i]);
  endtask

  // stop sending and let every expected word drain out
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_width(input logic [5:0] v);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    width_reg = v;
    widths_used++;
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0: return CH_TAB;
      1: return CH_NL;
      2: return 8'd11;
      3: return 8'd12;
      4: return CH_CR;
      default: return CH_SP;
    endcase
  endfunction

  // random item with idling that follows the three stall phases
  task automatic feed_random(input logic [7:0] b, input logic eot);
    if (rnd_items < RND_ITEMS / 3) begin
      tx_idle_pct = 27;
      rx_idle_pct = 54;
    end else if (rnd_items < (2 * RND_ITEMS) / 3) begin
      tx_idle_pct = 54;
      rx_idle_pct = 27;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    feed(b, eot, 1'b1);
    rnd_items++;
  endtask

  // stimulus
  initial begin
    wrap_out_t  typed_out;
    row_t       row;
    int         phase;
    int         nwords;
    int         wl;
    int         w_eff;
    logic [5:0] wsel;

    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_data    <= '0;
    push        <= 1'b0;
    byte_value  <= '0;
    end_of_text <= 1'b0;
    pop         <= 1'b0;
    cycle_count = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 54;
    errors = 0;
    bytes_checked = 0;
    words_fed = 0;
    rnd_items = 0;
    widths_used = 0;

    width_reg     = 6'd62;
    word_len      = 0;
    line_len      = 0;
    in_word       = 1'b0;
    streaming     = 1'b0;
    prev_nl       = 1'b0;
    para_pending  = 1'b0;
    overlong_seen = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WIDTH) begin
        set_width(row.val[5:0]);
      end else begin
        feed(row.val, row.kind == ROW_END, !row.typed);
        if (row.typed && row.has_out) begin
          typed_out.ch   = row.ch;
          typed_out.last = 1'b1;
          typed_out.done = row.done;
          typed_out.ovf  = row.ovf;
          expected_bytes.push_back(typed_out);
        end
      end
    end

    // random texts, one width per text
    phase = 0;
    while (rnd_items < RND_ITEMS) begin
      case (phase % 6)
        0: wsel = 6'($urandom_range(1, 12));
        1: wsel = 6'd62;
        2: wsel = 6'd0;
        3: wsel = 6'($urandom_range(2, 61));
        4: wsel = 6'd1;
        default: wsel = 6'd63;
      endcase
      set_width(wsel);
      w_eff = (int'(wsel) > MAX_WIDTH) ? MAX_WIDTH : int'(wsel);

      nwords = $urandom_range(2, 7);
      for (int wi = 0; wi < nwords && rnd_items < RND_ITEMS; wi++) begin
        if ($urandom_range(9) == 0)
          feed_random(8'($urandom_range(255)), 1'b0);
        if ($urandom_range(3) == 0) begin
          feed_random(CH_NL, 1'b0);
          feed_random(CH_NL, 1'b0);
        end else begin
          repeat ($urandom_range(1, 2)) feed_random(blank_char(), 1'b0);
        end
        // mostly short words, some around the width
        if ($urandom_range(3) != 0)
          wl = $urandom_range(1, (w_eff + 2 < 8) ? w_eff + 2 : 8);
        else
          wl = $urandom_range(1, w_eff + 2);
        repeat (wl) feed_random(word_char(), 1'b0);
      end
      if ($urandom_range(2) == 0)
        feed_random(blank_char(), 1'b0);
      feed_random(8'($urandom_range(255)), 1'b1);
      phase++;
    end

    wait_idle();

    $display("covered %0d input words (%0d random) over %0d width settings",
             words_fed, rnd_items, widths_used);
    $display("checked %0d output words, %0d mismatches", bytes_checked, errors);
    if (errors == 0 && expected_bytes.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
